// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sequencer RTL file of the component counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UFCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UFCC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define UFCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define UFCC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/ufcc_pkg.sv =====
// Package with the types and constants of the union-find component counter.
`default_nettype none
package ufcc_pkg;

	localparam int DEF_MAX_NODES = 256;
	localparam int RANK_W = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_MERGE_MODE = 1'b1;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic       connected;
		logic       last;
	} ufcc_item_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
	} ufcc_res_t;

endpackage
`default_nettype wire

// ===== rtl/ufcc_seq.sv =====
// Sequencer with the parent, size and rank memories: find, compress, merge and count.
`default_nettype none
`include "assert_macros.svh"
module ufcc_seq #(
	parameter int MAX_NODES = ufcc_pkg::DEF_MAX_NODES,
	localparam int IDX_W = $clog2(MAX_NODES),
	localparam int N_W = $clog2(MAX_NODES + 1),
	localparam int CMP_W = (N_W > ufcc_pkg::COUNT_W) ? N_W : ufcc_pkg::COUNT_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ufcc_pkg::ufcc_item_t item,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic [CMP_W-1:0]     n_act,
	input  wire logic                 merge_mode,
	output ufcc_pkg::ufcc_res_t       res,
	input  wire logic                 res_ready
);
	import ufcc_pkg::*;

	localparam int SIZE_W = N_W;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_SDRAIN,
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_COMP,
		ST_MRDA,
		ST_MRDB,
		ST_MERGE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0] parent_mem [MAX_NODES];
	logic [SIZE_W-1:0] size_mem [MAX_NODES];
	logic [RANK_W-1:0] rank_mem [MAX_NODES];

	logic [IDX_W-1:0] p_raddr, p_waddr, p_wdata, p_rdata;
	logic             p_we;
	logic [IDX_W-1:0] m_raddr;
	logic             s_we, k_we;
	logic [IDX_W-1:0] s_waddr, k_waddr;
	logic [SIZE_W-1:0] s_wdata, s_rdata;
	logic [RANK_W-1:0] k_wdata, k_rdata;

	logic [IDX_W-1:0] cur_q, start_q, root_q, col_q, ra_q, rb_q, i_q, i_s1;
	logic             which_q, last_q, cnt_en_q, v_s1;
	logic [N_W-1:0]   cnt_q;
	logic [SIZE_W-1:0] sa_q;
	logic [RANK_W-1:0] rka_q;

	logic             fd;
	logic [IDX_W-1:0] fd_root;
	logic             a_lose;
	logic [IDX_W-1:0] winner, loser;
	logic             do_merge;
	logic             hit;
	logic [CMP_W-1:0] cnt_ext;

	assign item_ready = (state_q == ST_IDLE);
	assign do_merge = item.connected && (CMP_W'(item.row) < n_act) && (CMP_W'(item.col) < n_act);
	assign a_lose = merge_mode ? (rka_q < k_rdata) : (sa_q < s_rdata);
	assign winner = a_lose ? rb_q : ra_q;
	assign loser = a_lose ? ra_q : rb_q;
	assign hit = v_s1 && cnt_en_q && (CMP_W'(i_s1) < n_act) && (p_rdata == i_s1);
	assign cnt_ext = CMP_W'(cnt_q);

	always_comb begin
		res.valid = (state_q == ST_EMIT);
		res.count = (cnt_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_W-1:0];
	end

	always_comb begin
		fd = 1'b0;
		fd_root = cur_q;
		if (state_q == ST_WALK && p_rdata == cur_q && cur_q == start_q) begin
			fd = 1'b1;
		end else if (state_q == ST_COMP && p_rdata == root_q) begin
			fd = 1'b1;
			fd_root = root_q;
		end
	end

	always_comb begin
		p_raddr = cur_q;
		p_we = 1'b0;
		p_waddr = cur_q;
		p_wdata = root_q;
		m_raddr = ra_q;
		s_we = 1'b0;
		s_waddr = winner;
		s_wdata = sa_q + s_rdata;
		k_we = 1'b0;
		k_waddr = ra_q;
		k_wdata = RANK_W'(rka_q + 1'b1);
		unique case (state_q)
			ST_SWEEP: begin
				p_raddr = i_q;
				p_we = 1'b1;
				p_waddr = i_q;
				p_wdata = i_q;
				s_we = 1'b1;
				s_waddr = i_q;
				s_wdata = SIZE_W'(1);
				k_we = 1'b1;
				k_waddr = i_q;
				k_wdata = '0;
			end
			ST_IDLE: p_raddr = IDX_W'(item.row);
			ST_WALK: p_raddr = (p_rdata == cur_q) ? start_q : p_rdata;
			ST_COMP: begin
				p_raddr = p_rdata;
				p_we = 1'b1;
			end
			ST_MRDB: m_raddr = rb_q;
			ST_MERGE: begin
				p_we = 1'b1;
				p_waddr = loser;
				p_wdata = winner;
				s_we = !merge_mode;
				k_we = merge_mode && (rka_q == k_rdata) && (rka_q != RANK_MAX);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			parent_mem[p_waddr] <= p_wdata;
		end
		p_rdata <= parent_mem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			size_mem[s_waddr] <= s_wdata;
		end
		s_rdata <= size_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (k_we) begin
			rank_mem[k_waddr] <= k_wdata;
		end
		k_rdata <= rank_mem[m_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			i_q <= '0;
			cnt_en_q <= 1'b0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			which_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			i_s1 <= i_q;
			if (hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q) inside
				ST_SWEEP: begin
					i_q <= i_q + 1'b1;
					if (i_q == IDX_W'(MAX_NODES - 1)) begin
						state_q <= ST_SDRAIN;
					end
				end
				ST_SDRAIN: state_q <= cnt_en_q ? ST_EMIT : ST_IDLE;
				ST_IDLE: begin
					if (item_valid) begin
						last_q <= item.last;
						start_q <= IDX_W'(item.row);
						cur_q <= IDX_W'(item.row);
						col_q <= IDX_W'(item.col);
						which_q <= 1'b0;
						if (do_merge) begin
							state_q <= ST_WALK;
						end else if (item.last) begin
							state_q <= ST_SWEEP;
							cnt_en_q <= 1'b1;
							cnt_q <= '0;
							i_q <= '0;
						end
					end
				end
				ST_FETCH: state_q <= ST_WALK;
				ST_WALK, ST_COMP: begin
					if (fd) begin
						if (!which_q) begin
							ra_q <= fd_root;
							start_q <= col_q;
							cur_q <= col_q;
							which_q <= 1'b1;
							state_q <= ST_FETCH;
						end else begin
							rb_q <= fd_root;
							if (fd_root != ra_q) begin
								state_q <= ST_MRDA;
							end else if (last_q) begin
								state_q <= ST_SWEEP;
								cnt_en_q <= 1'b1;
								cnt_q <= '0;
								i_q <= '0;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end else if (state_q == ST_WALK) begin
						if (p_rdata == cur_q) begin
							root_q <= cur_q;
							cur_q <= start_q;
							state_q <= ST_COMP;
						end else begin
							cur_q <= p_rdata;
						end
					end else begin
						cur_q <= p_rdata;
					end
				end
				ST_MRDA: state_q <= ST_MRDB;
				ST_MRDB: begin
					sa_q <= s_rdata;
					rka_q <= k_rdata;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (last_q) begin
						state_q <= ST_SWEEP;
						cnt_en_q <= 1'b1;
						cnt_q <= '0;
						i_q <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`UFCC_ASSERT(a_comp_not_root, clk, arst_n, (state_q == ST_COMP) |-> (cur_q != root_q), "compression reached the root")
	`UFCC_ASSERT(a_merge_roots_differ, clk, arst_n, (state_q == ST_MERGE) |-> (ra_q != rb_q), "merge of one root")
	`UFCC_ASSERT(a_count_bounded, clk, arst_n, res.valid |-> (cnt_ext <= n_act), "count above node count")
	`UFCC_ASSERT_NEXT(a_emit_holds, clk, arst_n, (state_q == ST_EMIT) && !res_ready, state_q == ST_EMIT, "result dropped")

endmodule
`default_nettype wire

// ===== rtl/union_find_component_counter.sv =====
// Top level of the union-find component counter: ports, registers and result word.
// An unconnected or ignored word merges nothing. A connected word in range finds the
// root of its row and then of its column, compressing each path, and merges the roots if
// they differ. After the last word a sweep counts the roots and reinitializes the store,
// and the count word is then loaded into the output register once that register is free.
// Asynchronous reset clears control state and runs a clearing sweep, during which no word
// is accepted; register writes are taken at all times.
`default_nettype none
module union_find_component_counter #(
	parameter int MAX_NODES = ufcc_pkg::DEF_MAX_NODES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // row_index [7:0], column_index [15:8]
	input  wire logic [0:0]  s_axis_tuser,  // connected [0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // component_count [8:0], zero pad [15:9]
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_wdata
);
	import ufcc_pkg::*;

	localparam int N_W = $clog2(MAX_NODES + 1);
	localparam int CMP_W = (N_W > COUNT_W) ? N_W : COUNT_W;

	logic [COUNT_W-1:0] node_count_q;
	logic               merge_mode_q;
	logic [CMP_W-1:0]   n_act;
	logic               m_valid_q;
	logic [COUNT_W-1:0] m_count_q;
	logic               res_ready;
	ufcc_item_t         item;
	ufcc_res_t          res;

	assign item.row = s_axis_tdata[7:0];
	assign item.col = s_axis_tdata[15:8];
	assign item.connected = s_axis_tuser[0];
	assign item.last = s_axis_tlast;

	assign n_act = (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
		: CMP_W'(node_count_q);
	assign res_ready = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {{(16 - COUNT_W){1'b0}}, m_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			merge_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_wdata;
				REG_MERGE_MODE: merge_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			m_count_q <= res.count;
		end
	end

	ufcc_seq #(
		.MAX_NODES(MAX_NODES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(s_axis_tvalid),
		.item_ready(s_axis_tready),
		.n_act(n_act),
		.merge_mode(merge_mode_q),
		.res(res),
		.res_ready(res_ready)
	);

endmodule
`default_nettype wire

// ===== verif/union_find_component_counter_test.sv =====
`timescale 1ns / 100ps
// Testbench of the union-find component counter: matrix entries checked against a disjoint-set predictor.
module union_find_component_counter_test;
	import ufcc_pkg::*;

	localparam int NODES = DEF_MAX_NODES;
	localparam int SETTLE_CYCLES = 4 * NODES + 96;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int ENTRY_TARGET = 1600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // row_index [7:0], column_index [15:8]
	logic [0:0]  s_axis_tuser = '0;   // connected [0]
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // component_count [8:0], zero pad [15:9]
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = REG_NODE_COUNT;
	logic [8:0]  cfg_wdata = '0;

	// Predicted disjoint-set forest and the register values it runs under.
	logic [7:0] forest_parent [NODES];
	logic [8:0] forest_size [NODES];
	logic [3:0] forest_rank [NODES];
	logic [8:0] model_node_count = NODE_COUNT_RESET;
	logic       model_merge_rank = 1'b0;

	ufcc_item_t entry_queue [$];
	ufcc_item_t entry_now;
	logic [8:0] count_queue [$];
	logic [8:0] count_want;

	int send_gap = 0;
	int recv_stall = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	int errors = 0;
	int counts_seen = 0;
	int entries_accepted = 0;
	int random_entries = 0;
	int settings_used = 0;

	union_find_component_counter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic void reset_forest();
		for (int i = 0; i < NODES; i++) begin
			forest_parent[i] = 8'(i);
			forest_size[i] = 9'd1;
			forest_rank[i] = '0;
		end
	endfunction

	// Walk to the root, then point every node on the walked path straight at it.
	function automatic logic [7:0] find_and_compress(input logic [7:0] x);
		logic [7:0] root;
		logic [7:0] cur;
		logic [7:0] nxt;
		int steps;
		root = x;
		steps = 0;
		while (forest_parent[root] != root && steps < NODES) begin
			root = forest_parent[root];
			steps++;
		end
		cur = x;
		steps = 0;
		while (cur != root && steps < NODES) begin
			nxt = forest_parent[cur];
			forest_parent[cur] = root;
			cur = nxt;
			steps++;
		end
		return root;
	endfunction

	function automatic void predict_entry(input ufcc_item_t w);
		int n;
		int roots;
		logic [7:0] ra;
		logic [7:0] rb;
		n = (model_node_count > NODES) ? NODES : int'(model_node_count);
		if (w.connected && w.row < n && w.col < n) begin
			ra = find_and_compress(w.row);
			rb = find_and_compress(w.col);
			if (ra != rb) begin
				if (!model_merge_rank) begin
					if (forest_size[ra] < forest_size[rb]) begin
						forest_parent[ra] = rb;
						forest_size[rb] = forest_size[rb] + forest_size[ra];
					end else begin
						forest_parent[rb] = ra;
						forest_size[ra] = forest_size[ra] + forest_size[rb];
					end
				end else if (forest_rank[ra] < forest_rank[rb]) begin
					forest_parent[ra] = rb;
				end else if (forest_rank[ra] > forest_rank[rb]) begin
					forest_parent[rb] = ra;
				end else begin
					forest_parent[rb] = ra;
					if (forest_rank[ra] != 4'd15) begin
						forest_rank[ra] = forest_rank[ra] + 4'd1;
					end
				end
			end
		end
		if (w.last) begin
			roots = 0;
			for (int i = 0; i < n; i++) begin
				if (forest_parent[i] == 8'(i)) begin
					roots++;
				end
			end
			count_queue.push_back(9'(roots));
			reset_forest();
		end
	endfunction

	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_entry(input int r, input int c, input bit conn, input bit last);
		ufcc_item_t w;
		w.row = 8'(r);
		w.col = 8'(c);
		w.connected = conn;
		w.last = last;
		entry_queue.push_back(w);
	endfunction

	// One matrix, mostly in-range edges, with some entries spread over the whole index range.
	function automatic void queue_matrix(input int eff);
		int len;
		int r;
		int c;
		bit conn;
		if (eff == 0) begin
			len = $urandom_range(1, 4);
		end else if (eff <= 16) begin
			len = $urandom_range(1, 3 * eff + 2);
		end else if (eff <= 64) begin
			len = $urandom_range(eff / 2, 2 * eff);
		end else begin
			len = $urandom_range(20, eff);
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 85 && eff > 0) begin
				r = $urandom_range(0, eff - 1);
				c = $urandom_range(0, eff - 1);
				conn = $urandom_range(0, 99) < 75;
			end else begin
				r = $urandom_range(0, 255);
				c = $urandom_range(0, 255);
				conn = $urandom_range(0, 1);
			end
			queue_entry(r, c, conn, i == len - 1);
			random_entries++;
		end
	endfunction

	task automatic write_reg(input logic idx, input logic [8:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_NODE_COUNT) begin
			model_node_count = value;
		end else begin
			model_merge_rank = value[0];
		end
		settings_used++;
	endtask

	// Hold off until every queued word is taken and every count has come back.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (entry_queue.size() != 0 || s_axis_tvalid || count_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_entry(entry_now);
				entries_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (entry_queue.size() != 0) begin
					entry_now = entry_queue.pop_front();
					s_axis_tdata <= {entry_now.col, entry_now.row};
					s_axis_tuser <= entry_now.connected;
					s_axis_tlast <= entry_now.last;
					s_axis_tvalid <= 1'b1;
					send_gap = pick_gap(send_gap_pct);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (count_queue.size() == 0) begin
					$display("%0t: component count %0d arrived with none expected", $time,
						m_axis_tdata);
					errors++;
				end else begin
					count_want = count_queue.pop_front();
					counts_seen++;
					if (m_axis_tdata !== {7'd0, count_want}) begin
						$display("%0t: component count mismatch: expected %0d, actual %0d", $time,
							count_want, m_axis_tdata);
						errors++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall = pick_gap(recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[union_find_component_counter] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int pick;
		int node_sel;
		int eff;
		int pct_choice [4];
		pct_choice = '{0, 10, 40, 80};
		reset_forest();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: full node range, merge by size.
		send_gap_pct = 30;
		recv_stall_pct = 30;
		@(negedge clk);
		queue_entry(7, 7, 0, 1);
		queue_entry(0, 255, 1, 0);
		queue_entry(255, 255, 1, 0);
		queue_entry(5, 6, 0, 0);
		queue_entry(1, 2, 1, 0);
		queue_entry(2, 3, 1, 0);
		queue_entry(1, 3, 1, 0);
		queue_entry(0, 0, 1, 1);
		wait_drained();

		// Four nodes by rank, with indices past the range and a last word out of range.
		write_reg(REG_MERGE_MODE, 9'd1);
		write_reg(REG_NODE_COUNT, 9'd4);
		@(negedge clk);
		queue_entry(3, 4, 1, 0);
		queue_entry(4, 0, 1, 0);
		queue_entry(0, 1, 1, 0);
		queue_entry(2, 3, 1, 0);
		queue_entry(0, 2, 1, 0);
		queue_entry(255, 0, 1, 1);
		wait_drained();

		write_reg(REG_NODE_COUNT, 9'd0);
		@(negedge clk);
		queue_entry(0, 0, 1, 0);
		queue_entry(0, 1, 1, 1);
		wait_drained();

		// Node count above capacity, then lowered in the middle of a matrix so that a root
		// beyond the new range is still followed.
		write_reg(REG_MERGE_MODE, 9'd0);
		write_reg(REG_NODE_COUNT, 9'd511);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		queue_entry(100, 2, 1, 0);
		queue_entry(10, 20, 1, 0);
		wait_drained();
		write_reg(REG_NODE_COUNT, 9'd8);
		@(negedge clk);
		queue_entry(2, 3, 1, 0);
		queue_entry(200, 7, 1, 0);
		queue_entry(3, 3, 0, 1);
		wait_drained();

		while (random_entries < ENTRY_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				node_sel = 0;
			end else if (pick == 1) begin
				node_sel = 1;
			end else if (pick == 2) begin
				node_sel = 2;
			end else if (pick == 3) begin
				node_sel = 256;
			end else if (pick == 4) begin
				node_sel = 511;
			end else if (pick == 5) begin
				node_sel = $urandom_range(257, 510);
			end else if (pick <= 8) begin
				node_sel = $urandom_range(17, 255);
			end else begin
				node_sel = $urandom_range(3, 16);
			end
			eff = (node_sel > NODES) ? NODES : node_sel;
			write_reg(REG_NODE_COUNT, 9'(node_sel));
			write_reg(REG_MERGE_MODE, 9'($urandom_range(0, 1)));
			send_gap_pct = pct_choice[$urandom_range(0, 3)];
			recv_stall_pct = pct_choice[$urandom_range(0, 3)];
			@(negedge clk);
			repeat ($urandom_range(2, 5)) begin
				if (random_entries < ENTRY_TARGET) begin
					queue_matrix(eff);
				end
			end
			wait_drained();
		end

		$display("Checked %0d component counts from %0d accepted words under %0d register writes.",
			counts_seen, entries_accepted, settings_used);
		$display("Node counts from 0 to 511, both merge modes and a mid-matrix change were run.");
		if (errors == 0) begin
			$display("[union_find_component_counter] OK");
		end else begin
			$display("[union_find_component_counter] ERROR");
		end
		$finish;
	end

endmodule
